/* hw/rtl/u8vs_pkg.sv */
// Package: byte classes and range limits for the UTF-8 validator/splitter.
`timescale 1ns / 1ps
`default_nettype none
package u8vs_pkg;

    // Lead byte classes
    localparam logic [7:0] ASCII_MAX    = 8'h7F;
    localparam logic [7:0] LEAD2_MIN    = 8'hC2;
    localparam logic [7:0] LEAD2_MAX    = 8'hDF;
    localparam logic [7:0] LEAD3_MIN    = 8'hE0;
    localparam logic [7:0] LEAD3_MAX    = 8'hEF;
    localparam logic [7:0] LEAD4_MIN    = 8'hF0;
    localparam logic [7:0] LEAD4_MAX    = 8'hF4;

    // Leads that narrow the range of the second byte
    localparam logic [7:0] LEAD_E0      = 8'hE0;
    localparam logic [7:0] LEAD_ED      = 8'hED;
    localparam logic [7:0] LEAD_F0      = 8'hF0;
    localparam logic [7:0] LEAD_F4      = 8'hF4;

    // Continuation byte limits
    localparam logic [7:0] CONT_MIN     = 8'h80;
    localparam logic [7:0] CONT_MAX     = 8'hBF;
    localparam logic [7:0] E0_CONT_MIN  = 8'hA0;
    localparam logic [7:0] ED_CONT_MAX  = 8'h9F;
    localparam logic [7:0] F0_CONT_MIN  = 8'h90;
    localparam logic [7:0] F4_CONT_MAX  = 8'h8F;

    // Character lengths
    localparam logic [2:0] LEN_1        = 3'd1;
    localparam logic [2:0] LEN_2        = 3'd2;
    localparam logic [2:0] LEN_3        = 3'd3;
    localparam logic [2:0] LEN_4        = 3'd4;
    localparam logic [2:0] LEN_ERR      = 3'd0;

    // Continuation counts
    localparam logic [1:0] REM_NONE     = 2'd0;
    localparam logic [1:0] REM_ONE      = 2'd1;
    localparam logic [1:0] REM_TWO      = 2'd2;
    localparam logic [1:0] REM_THREE    = 2'd3;

    // Byte position of the second byte within a character
    localparam logic [1:0] POS_SECOND   = 2'd1;

endpackage
`default_nettype wire

/* hw/rtl/u8vs_if.sv */
// Interfaces: valid/ready channels for input bytes and character results.
`timescale 1ns / 1ps
`default_nettype none
interface u8vs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface u8vs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] unit_bytes;
    logic [2:0]  unit_length;
    logic        is_error;
    logic        is_last;

    modport source (output valid, output unit_bytes, output unit_length,
                    output is_error, output is_last, input ready);
    modport sink   (input valid, input unit_bytes, input unit_length,
                    input is_error, input is_last, output ready);
endinterface
`default_nettype wire

/* hw/rtl/utf8_validate_split.sv */
// Top level: strict UTF-8 validator that splits a byte string into characters.
//
//  channel | dir | payload                                        | transfer
//  i_in    | in  | data_byte[7:0], final_byte                     | valid & ready
//  o_out   | out | unit_bytes[31:0], unit_length[2:0], is_error,  | valid & ready
//          |     | is_last                                        |
//
//  One byte per cycle sustained while results are taken; a byte's result passes
//  through the input register, then decode into the result register.
//  The decode state (gathered bytes, count, lead, error flag) updates as each
//  byte leaves the input register, so consecutive bytes flow without bubbles.
//  A stalled result register holds the input register; input ready drops only
//  while both are full and the result is not taken.
//  Reset is synchronous, active low, and returns the decode state to idle.
`timescale 1ns / 1ps
`default_nettype none
module utf8_validate_split (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    u8vs_in_if.sink     i_in,
    u8vs_out_if.source  o_out
);

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_byte;
    logic        r_fin;

    // Decode state
    logic [23:0] r_gath, n_gath;
    logic [1:0]  r_rem, n_rem;
    logic [2:0]  r_seq, n_seq;
    logic [7:0]  r_lead, n_lead;
    logic        r_err, n_err;

    // Result register
    logic        r_out_valid;
    logic [31:0] r_out_bytes, n_out_bytes;
    logic [2:0]  r_out_len, n_out_len;
    logic        r_out_err, n_out_err;
    logic        r_out_last, n_out_last;
    logic        n_out_valid;

    logic        advance;
    logic        have_char;
    logic [1:0]  pos;
    logic [7:0]  lo;
    logic [7:0]  hi;
    logic [31:0] packed_val;

    // Move a byte into decode when the result register can take its result
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // Capture the incoming byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.ready && i_in.valid) begin
            r_byte <= i_in.data_byte;
            r_fin  <= i_in.final_byte;
        end
    end

    // Work out the allowed range of the continuation byte
    always_comb begin
        pos = r_seq[1:0] - r_rem;
        lo  = u8vs_pkg::CONT_MIN;
        hi  = u8vs_pkg::CONT_MAX;
        if (pos == u8vs_pkg::POS_SECOND) begin
            if (r_lead == u8vs_pkg::LEAD_E0) begin
                lo = u8vs_pkg::E0_CONT_MIN;
            end else if (r_lead == u8vs_pkg::LEAD_ED) begin
                hi = u8vs_pkg::ED_CONT_MAX;
            end else if (r_lead == u8vs_pkg::LEAD_F0) begin
                lo = u8vs_pkg::F0_CONT_MIN;
            end else if (r_lead == u8vs_pkg::LEAD_F4) begin
                hi = u8vs_pkg::F4_CONT_MAX;
            end
        end
        packed_val = {8'h00, r_gath} | ({24'h000000, r_byte} << {pos, 3'b000});
    end

    // Decode one byte: advance the sequence, flag errors, form the result
    always_comb begin
        n_gath      = r_gath;
        n_rem       = r_rem;
        n_seq       = r_seq;
        n_lead      = r_lead;
        n_err       = r_err;
        have_char   = 1'b0;
        n_out_bytes = 32'h0000_0000;
        n_out_len   = u8vs_pkg::LEN_ERR;
        n_out_err   = 1'b0;
        n_out_last  = 1'b0;

        if (!r_err) begin
            if (r_rem == u8vs_pkg::REM_NONE) begin
                unique case (r_byte) inside
                    [8'h00 : u8vs_pkg::ASCII_MAX]: begin
                        have_char   = 1'b1;
                        n_out_bytes = {24'h000000, r_byte};
                        n_out_len   = u8vs_pkg::LEN_1;
                    end
                    [u8vs_pkg::LEAD2_MIN : u8vs_pkg::LEAD2_MAX]: begin
                        n_seq  = u8vs_pkg::LEN_2;
                        n_rem  = u8vs_pkg::REM_ONE;
                        n_gath = {16'h0000, r_byte};
                        n_lead = r_byte;
                    end
                    [u8vs_pkg::LEAD3_MIN : u8vs_pkg::LEAD3_MAX]: begin
                        n_seq  = u8vs_pkg::LEN_3;
                        n_rem  = u8vs_pkg::REM_TWO;
                        n_gath = {16'h0000, r_byte};
                        n_lead = r_byte;
                    end
                    [u8vs_pkg::LEAD4_MIN : u8vs_pkg::LEAD4_MAX]: begin
                        n_seq  = u8vs_pkg::LEN_4;
                        n_rem  = u8vs_pkg::REM_THREE;
                        n_gath = {16'h0000, r_byte};
                        n_lead = r_byte;
                    end
                    default: begin
                        n_err = 1'b1;
                    end
                endcase
            end else if (r_byte < lo || r_byte > hi) begin
                n_err = 1'b1;
            end else if (r_rem == u8vs_pkg::REM_ONE) begin
                // Last continuation: emit the character and go idle
                have_char   = 1'b1;
                n_out_bytes = packed_val;
                n_out_len   = r_seq;
                n_rem       = u8vs_pkg::REM_NONE;
                n_gath      = 24'h000000;
                n_seq       = 3'd0;
                n_lead      = 8'h00;
            end else begin
                n_rem  = r_rem - 2'd1;
                n_gath = packed_val[23:0];
            end
        end

        n_out_valid = have_char || r_fin;

        // End of string: report the character or a single error, then clear
        if (r_fin) begin
            n_out_last = 1'b1;
            if (n_err || n_rem != u8vs_pkg::REM_NONE || !have_char) begin
                n_out_bytes = 32'h0000_0000;
                n_out_len   = u8vs_pkg::LEN_ERR;
                n_out_err   = 1'b1;
            end
            n_gath = 24'h000000;
            n_rem  = u8vs_pkg::REM_NONE;
            n_seq  = 3'd0;
            n_lead = 8'h00;
            n_err  = 1'b0;
        end
    end

    // Update decode state as each byte is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gath <= 24'h000000;
            r_rem  <= u8vs_pkg::REM_NONE;
            r_seq  <= 3'd0;
            r_lead <= 8'h00;
            r_err  <= 1'b0;
        end else if (advance) begin
            r_gath <= n_gath;
            r_rem  <= n_rem;
            r_seq  <= n_seq;
            r_lead <= n_lead;
            r_err  <= n_err;
        end
    end

    // Load or drain the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= n_out_valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && n_out_valid) begin
            r_out_bytes <= n_out_bytes;
            r_out_len   <= n_out_len;
            r_out_err   <= n_out_err;
            r_out_last  <= n_out_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.unit_bytes  = r_out_bytes;
    assign o_out.unit_length = r_out_len;
    assign o_out.is_error    = r_out_err;
    assign o_out.is_last     = r_out_last;

    // A character in progress has had its lead, so its length exceeds the count left
    a_seq_covers_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_err && r_rem != u8vs_pkg::REM_NONE) |-> (r_seq > {1'b0, r_rem}))
        else $error("sequence length does not cover remaining continuations");

    // The final byte leaves the decoder idle for the next string
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_fin) |=> (r_rem == u8vs_pkg::REM_NONE && !r_err))
        else $error("decode state not cleared after final byte");

    // An error result carries no character and closes the string
    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |->
            (r_out_len == u8vs_pkg::LEN_ERR && r_out_last && r_out_bytes == 32'h0000_0000))
        else $error("malformed error result");

endmodule
`default_nettype wire
